/* hdl/gtg_pkg.sv */
package gtg_pkg;

	localparam int CORDIC_ITERATIONS = 24;
	localparam int CORDIC_STEPS = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;

	localparam int GUARD_BITS = 8;
	localparam int CW = 44;          // cordic x/y width
	localparam int ZW = 34;          // angle accumulator width, Q4.30

	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629712;
	localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

	typedef enum logic [2:0] {
		REG_TARGET_X      = 3'd0,
		REG_TARGET_Y      = 3'd1,
		REG_LINEAR_GAIN   = 3'd2,
		REG_ANGULAR_GAIN  = 3'd3,
		REG_ARRIVE_RADIUS = 3'd4
	} cfg_reg_t;

	typedef logic signed [CW-1:0] cvec_t;
	typedef logic signed [ZW-1:0] cang_t;

	localparam logic [29:0] ATAN_Q30 [0:31] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
		30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
		30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
		30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
		30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
		30'h00000001, 30'h00000000
	};

endpackage

/* hdl/go_to_goal_velocity_command.sv */
// go-to-goal proportional controller
// command channel: a pose (pos_x, pos_y, heading) is taken on a rising edge
// with start high and busy low. results come out one per cycle on
// fwd_speed / turn_rate / is_stop / last, marked by result_valid;
// the receiver must take each beat in the cycle it appears.
// configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register (target_x, target_y, linear_gain, angular_gain, arrive_radius),
// cfg_data carries the value. cfg_ready is always high.
// a pose passes CORDIC_ITERATIONS + 6 registers (30): the offset,
// the quadrant fold, one cordic stage per iteration, the gain compensation
// multiply, the rounding stage, the gain multiply and the output register.
// throughput: one pose per cycle while busy is low. when the distance is
// below arrive_radius the move beat (last low) is followed by a zero stop
// beat (is_stop, last); busy is high while the move beat is on the ports,
// and while busy is high the whole pipeline holds.
// reset clears all valid bits and the pending stop and loads the default
// register values; items in flight are dropped.
module go_to_goal_velocity_command (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [18:0]  heading,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                result_valid,
	output logic signed [31:0]  fwd_speed,
	output logic signed [31:0]  turn_rate,
	output logic                is_stop,
	output logic                last
);
	import gtg_pkg::*;

	localparam int N = CORDIC_STEPS;

	logic signed [31:0] target_x_q, target_y_q;
	logic [19:0] linear_gain_q, angular_gain_q;
	logic [30:0] arrive_radius_q;
	logic stop_pend_q;
	logic en;

	assign cfg_ready = 1'b1;
	assign busy = stop_pend_q;
	assign en = !stop_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= '0;
			target_y_q <= '0;
			linear_gain_q <= 20'd6554;
			angular_gain_q <= 20'd65536;
			arrive_radius_q <= 31'd16384;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_TARGET_X: target_x_q <= cfg_data;
				REG_TARGET_Y: target_y_q <= cfg_data;
				REG_LINEAR_GAIN: linear_gain_q <= cfg_data[19:0];
				REG_ANGULAR_GAIN: angular_gain_q <= cfg_data[19:0];
				REG_ARRIVE_RADIUS: arrive_radius_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// stage 1: offset to target
	logic v_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [18:0] hd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 33'(target_x_q) - 33'(pos_x);
			dy_s1 <= 33'(target_y_q) - 33'(pos_y);
			hd_s1 <= heading;
		end
	end

	// stage 2: quadrant fold, then one register per cordic iteration
	cvec_t cx_s2 [0:N];
	cvec_t cy_s2 [0:N];
	cang_t cz_s2 [0:N];
	logic signed [18:0] hd_s2 [0:N];
	logic zero_s2 [0:N];
	logic v_s2 [0:N];

	cvec_t dxg, dyg;
	assign dxg = CW'(dx_s1) <<< GUARD_BITS;
	assign dyg = CW'(dy_s1) <<< GUARD_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			hd_s2[0] <= hd_s1;
			zero_s2[0] <= (dx_s1 == '0) && (dy_s1 == '0);
			if (dx_s1 < 0) begin
				if (dy_s1 >= 0) begin
					cx_s2[0] <= dyg;
					cy_s2[0] <= -dxg;
					cz_s2[0] <= HALF_PI_Q30;
				end else begin
					cx_s2[0] <= -dyg;
					cy_s2[0] <= dxg;
					cz_s2[0] <= -HALF_PI_Q30;
				end
			end else begin
				cx_s2[0] <= dxg;
				cy_s2[0] <= dyg;
				cz_s2[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		cang_t at;
		assign at = cang_t'({4'b0000, ATAN_Q30[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				hd_s2[i+1] <= hd_s2[i];
				zero_s2[i+1] <= zero_s2[i];
				if (!cy_s2[i][CW-1]) begin
					cx_s2[i+1] <= cx_s2[i] + (cy_s2[i] >>> i);
					cy_s2[i+1] <= cy_s2[i] - (cx_s2[i] >>> i);
					cz_s2[i+1] <= cz_s2[i] + at;
				end else begin
					cx_s2[i+1] <= cx_s2[i] - (cy_s2[i] >>> i);
					cy_s2[i+1] <= cy_s2[i] + (cx_s2[i] >>> i);
					cz_s2[i+1] <= cz_s2[i] - at;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s2[i+1] <= 1'b0;
			else if (en) v_s2[i+1] <= v_s2[i];
		end
	end

	// stage 3: gain compensation products, bearing rounding
	logic [42:0] ux;
	logic [63:0] plo_full;
	cang_t zr;
	logic [42:0] phi_s3;
	logic [31:0] plo_s3;
	logic signed [19:0] brg_s3;
	logic signed [18:0] hd_s3;
	logic v_s3;

	assign ux = cx_s2[N][CW-1] ? '0 : cx_s2[N][42:0];
	assign plo_full = 64'(ux[31:0]) * 64'(INV_GAIN_Q32);
	assign zr = cz_s2[N] + cang_t'(1 <<< 13);

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s3 <= 43'(ux[42:32]) * 43'(INV_GAIN_Q32);
			plo_s3 <= plo_full[63:32];
			brg_s3 <= zero_s2[N] ? '0 : zr[ZW-1:14];
			hd_s3 <= hd_s2[N];
		end
	end

	// stage 4: distance and heading error
	logic [43:0] dsum;
	logic [35:0] dist_s4;
	logic signed [20:0] diff_s4;
	logic v_s4;

	assign dsum = 44'(phi_s3) + 44'(plo_s3) + 44'(1 << (GUARD_BITS - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s4 <= dsum[43:GUARD_BITS];
			diff_s4 <= 21'(brg_s3) - 21'(hd_s3);
		end
	end

	// stage 5: gain products, arrival test
	logic [55:0] lp_s5;
	logic signed [41:0] ap_s5;
	logic arr_s5;
	logic v_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			lp_s5 <= 56'(dist_s4) * 56'(linear_gain_q);
			ap_s5 <= 42'(diff_s4) * $signed({22'd0, angular_gain_q});
			arr_s5 <= dist_s4 < 36'(arrive_radius_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2[0] <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= start;
			v_s2[0] <= v_s1;
			v_s3 <= v_s2[N];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// output register: round, and saturate the forward speed
	logic [56:0] lr;
	logic [39:0] lin40;
	logic signed [42:0] ar;
	logic signed [31:0] lin_n, ang_n;

	assign lr = 57'(lp_s5) + 57'(1 << 15);
	assign lin40 = lr[55:16];
	assign lin_n = (lin40[39:31] != '0) ? 32'sh7FFFFFFF : $signed(lin40[31:0]);
	assign ar = 43'(ap_s5) + 43'(1 << 15);
	// the heading error product never leaves the 32 bit range
	assign ang_n = 32'($signed(ar[42:16]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			stop_pend_q <= 1'b0;
		end else if (stop_pend_q) begin
			result_valid <= 1'b1;
			stop_pend_q <= 1'b0;
		end else begin
			result_valid <= v_s5;
			stop_pend_q <= v_s5 && arr_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (stop_pend_q) begin
			fwd_speed <= '0;
			turn_rate <= '0;
			is_stop <= 1'b1;
			last <= 1'b1;
		end else begin
			fwd_speed <= lin_n;
			turn_rate <= ang_n;
			is_stop <= 1'b0;
			last <= !arr_s5;
		end
	end

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("stop pending held more than one cycle");
	a_move_then_stop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid && is_stop && last)
		else $error("arrival beat not followed by stop beat");
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_stop |-> last && fwd_speed == 0 && turn_rate == 0)
		else $error("stop beat not zero");
	a_busy_after_move: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> result_valid && !last)
		else $error("busy without arrival beat");

endmodule
